@@ sv/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared constants and types for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int FRAMES_DEF  = 64;
    localparam int ADDR_W_DEF  = 27;
    localparam int STAMP_W_DEF = 32;
    localparam int FRAME_W_DEF = 6;

    localparam int CFG_W     = 7;
    localparam int CFG_RESET = 64;

    localparam int COUNT_W = 32;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;
        logic strobe;
    } t_scan_ctl;

    // Status from the scan unit back to the sequencer.
    typedef struct packed {
        logic hit;
        logic hit_dirty;
        logic old_dirty;
    } t_scan_sts;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

@@ sv/lpr_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lpr_cfg_if
// Configuration write channel: one register, no index.
// ----------------------------------------------------------------------------
interface lpr_cfg_if ();
    logic                     valid;
    logic                     ready;
    logic [lpr_pkg::CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/lpr_in_if.sv @@
// ----------------------------------------------------------------------------
// lpr_in_if
// Reference channel: one memory reference per beat.
// ----------------------------------------------------------------------------
interface lpr_in_if #(
    parameter int ADDR_WIDTH = lpr_pkg::ADDR_W_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [ADDR_WIDTH-1:0] ref_value;

    modport source (output valid, output ref_value, input ready);
    modport sink   (input valid, input ref_value, output ready);
endinterface

@@ sv/lpr_out_if.sv @@
// ----------------------------------------------------------------------------
// lpr_out_if
// Result channel: one lookup result and the running totals per beat.
// ----------------------------------------------------------------------------
interface lpr_out_if #(
    parameter int FRAME_W = lpr_pkg::FRAME_W_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [FRAME_W-1:0]          frame_index;
    logic                        flushed;
    logic [lpr_pkg::COUNT_W-1:0] fault_total;
    logic [lpr_pkg::COUNT_W-1:0] flush_total;
    logic [lpr_pkg::COUNT_W-1:0] ref_total;

    modport source (output valid, output hit, output frame_index, output flushed,
                    output fault_total, output flush_total, output ref_total,
                    input ready);
    modport sink   (input valid, input hit, input frame_index, input flushed,
                    input fault_total, input flush_total, input ref_total,
                    output ready);
endinterface

@@ sv/lpr_frame_mem.sv @@
// ----------------------------------------------------------------------------
// lpr_frame_mem
// Frame table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lpr_frame_mem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 59,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/lpr_scan.sv @@
// ----------------------------------------------------------------------------
// lpr_scan
// Shared compare unit: takes one frame per strobe, keeps the first tag match
// and the oldest stamp seen.
// ----------------------------------------------------------------------------
module lpr_scan #(
    parameter int FRAME_W = 6,
    parameter int TAG_W   = 26,
    parameter int STAMP_W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lpr_pkg::t_scan_ctl   i_ctl,
    input  logic [FRAME_W-1:0]   i_idx,
    input  logic [TAG_W-1:0]     i_tag,
    input  logic [TAG_W-1:0]     i_ent_tag,
    input  logic [STAMP_W-1:0]   i_ent_stamp,
    input  logic                 i_ent_dirty,
    output lpr_pkg::t_scan_sts   o_sts,
    output logic [FRAME_W-1:0]   o_hit_idx,
    output logic [FRAME_W-1:0]   o_old_idx
);

    import lpr_pkg::*;

    logic               r_hit;
    logic               r_hit_dirty;
    logic [FRAME_W-1:0] r_hit_idx;
    logic               r_found;
    logic [STAMP_W-1:0] r_old_stamp;
    logic               r_old_dirty;
    logic [FRAME_W-1:0] r_old_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= 1'b0;
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_hit   <= 1'b0;
            r_found <= 1'b0;
        end else if (i_ctl.strobe) begin
            // Only the first match counts, frames arrive in index order.
            if (!r_hit && (i_ent_tag == i_tag)) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= i_idx;
                r_hit_dirty <= i_ent_dirty;
            end
            // Strict less-than keeps the lowest index on equal stamps.
            if (!r_found || (i_ent_stamp < r_old_stamp)) begin
                r_found     <= 1'b1;
                r_old_stamp <= i_ent_stamp;
                r_old_idx   <= i_idx;
                r_old_dirty <= i_ent_dirty;
            end
        end
    end

    assign o_sts.hit       = r_hit;
    assign o_sts.hit_dirty = r_hit_dirty;
    assign o_sts.old_dirty = r_old_dirty;
    assign o_hit_idx       = r_hit_idx;
    assign o_old_idx       = r_old_idx;

endmodule

@@ sv/lru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative frame table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One reference is handled at a time. The frame table sits in a memory with a
// single read port, and a shared compare unit looks at one frame per cycle,
// finding the tag match and the oldest frame in the same pass. A reference
// passes the scan, update and output states before the next accept; the scan
// covers the filled frames within the frames in use (at most FRAMES), and
// the result beat is held in an output register until taken.
// Frames are filled in order, so a fill count stands for the valid marks and
// no clearing pass is needed after reset. The frame count register may be
// written only while no reference is in flight.
module lru_page_replacement #(
    parameter int FRAMES      = lpr_pkg::FRAMES_DEF,
    parameter int ADDR_WIDTH  = lpr_pkg::ADDR_W_DEF,
    parameter int STAMP_WIDTH = lpr_pkg::STAMP_W_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpr_cfg_if.sink      i_cfg,
    lpr_in_if.sink       i_in,
    lpr_out_if.source    o_out
);

    import lpr_pkg::*;

    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int CMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int TAG_W   = ADDR_WIDTH - 1;
    localparam int ENT_W   = 1 + TAG_W + STAMP_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_OUT
    } t_state;

    t_state             r_state,  n_state;
    logic [CFG_W-1:0]   r_frames_in_use;
    logic [CNT_W-1:0]   r_fill,   n_fill;
    logic [FRAME_W-1:0] r_fp,     n_fp;
    logic [STAMP_WIDTH-1:0] r_time, n_time;
    logic [COUNT_W-1:0] r_faults, n_faults;
    logic [COUNT_W-1:0] r_flushes, n_flushes;
    logic [COUNT_W-1:0] r_refs,   n_refs;
    logic [CNT_W-1:0]   r_n,      n_n;
    logic [CNT_W-1:0]   r_lim,    n_lim;
    logic [CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic               r_pend,   n_pend;
    logic [FRAME_W-1:0] r_pend_idx, n_pend_idx;
    logic [TAG_W-1:0]   r_tag,    n_tag;
    logic               r_wr,     n_wr;
    logic               r_res_hit, n_res_hit;
    logic [FRAME_W-1:0] r_res_frame, n_res_frame;
    logic               r_res_flush, n_res_flush;
    logic               r_out_valid, n_out_valid;
    logic               r_out_hit, n_out_hit;
    logic [FRAME_W-1:0] r_out_frame, n_out_frame;
    logic               r_out_flush, n_out_flush;
    logic [COUNT_W-1:0] r_out_faults, n_out_faults;
    logic [COUNT_W-1:0] r_out_flushes, n_out_flushes;
    logic [COUNT_W-1:0] r_out_refs, n_out_refs;

    logic [CMP_W-1:0]   cfg_ext;
    logic [CNT_W-1:0]   n_act;
    logic               in_beat;
    t_scan_ctl          scan_ctl;
    t_scan_sts          scan_sts;
    logic [FRAME_W-1:0] hit_idx;
    logic [FRAME_W-1:0] old_idx;
    logic               rd_en;
    logic               wr_en;
    logic [FRAME_W-1:0] wr_addr;
    logic [ENT_W-1:0]   wr_data;
    logic [ENT_W-1:0]   rd_data;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_beat     = i_in.valid && (r_state == S_IDLE);

    // Frame count in use, clamped to 1..FRAMES.
    assign cfg_ext = CMP_W'(r_frames_in_use);
    always_comb begin
        if (cfg_ext == '0) begin
            n_act = CNT_W'(1);
        end else if (cfg_ext > CMP_W'(FRAMES)) begin
            n_act = CNT_W'(FRAMES);
        end else begin
            n_act = CNT_W'(cfg_ext);
        end
    end

    assign rd_en = (r_state == S_SCAN) && (r_rd_idx < r_lim);
    assign scan_ctl.clear  = in_beat;
    assign scan_ctl.strobe = (r_state == S_SCAN) && r_pend;

    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_fp          = r_fp;
        n_time        = r_time;
        n_faults      = r_faults;
        n_flushes     = r_flushes;
        n_refs        = r_refs;
        n_n           = r_n;
        n_lim         = r_lim;
        n_rd_idx      = r_rd_idx;
        n_pend        = r_pend;
        n_pend_idx    = r_pend_idx;
        n_tag         = r_tag;
        n_wr          = r_wr;
        n_res_hit     = r_res_hit;
        n_res_frame   = r_res_frame;
        n_res_flush   = r_res_flush;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_hit     = r_out_hit;
        n_out_frame   = r_out_frame;
        n_out_flush   = r_out_flush;
        n_out_faults  = r_out_faults;
        n_out_flushes = r_out_flushes;
        n_out_refs    = r_out_refs;
        wr_en         = 1'b0;
        wr_addr       = r_fp;
        wr_data       = {r_wr, r_tag, r_time};

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_n      = n_act;
                    n_time   = (r_time == {STAMP_WIDTH{1'b1}}) ?
                               r_time : r_time + STAMP_WIDTH'(1);
                    n_refs   = sat_inc(r_refs);
                    if (CNT_W'(r_fp) >= n_act) begin
                        n_fp = '0;
                    end
                    n_lim    = (r_fill < n_act) ? r_fill : n_act;
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                    n_tag    = i_in.ref_value[ADDR_WIDTH-1:1];
                    n_wr     = i_in.ref_value[0];
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_idx < r_lim) begin
                    n_rd_idx   = r_rd_idx + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[FRAME_W-1:0];
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                wr_en = 1'b1;
                if (scan_sts.hit) begin
                    wr_addr     = hit_idx;
                    wr_data     = {scan_sts.hit_dirty | r_wr, r_tag, r_time};
                    n_res_hit   = 1'b1;
                    n_res_frame = hit_idx;
                    n_res_flush = 1'b0;
                end else begin
                    n_faults  = sat_inc(r_faults);
                    n_res_hit = 1'b0;
                    if (CNT_W'(r_fp) == r_fill) begin
                        // The frame at the fill pointer is still free.
                        wr_addr     = r_fp;
                        n_res_frame = r_fp;
                        n_res_flush = 1'b0;
                        n_fill      = r_fill + CNT_W'(1);
                        n_fp        = (CNT_W'(r_fp) + CNT_W'(1) >= r_n) ?
                                      '0 : r_fp + FRAME_W'(1);
                    end else begin
                        wr_addr     = old_idx;
                        n_res_frame = old_idx;
                        n_res_flush = scan_sts.old_dirty;
                        if (scan_sts.old_dirty) begin
                            n_flushes = sat_inc(r_flushes);
                        end
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_hit     = r_res_hit;
                    n_out_frame   = r_res_frame;
                    n_out_flush   = r_res_flush;
                    n_out_faults  = r_faults;
                    n_out_flushes = r_flushes;
                    n_out_refs    = r_refs;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_frames_in_use <= CFG_W'(CFG_RESET);
            r_fill          <= '0;
            r_fp            <= '0;
            r_time          <= '0;
            r_faults        <= '0;
            r_flushes       <= '0;
            r_refs          <= '0;
            r_n             <= '0;
            r_lim           <= '0;
            r_rd_idx        <= '0;
            r_pend          <= 1'b0;
            r_pend_idx      <= '0;
            r_tag           <= '0;
            r_wr            <= 1'b0;
            r_res_hit       <= 1'b0;
            r_res_frame     <= '0;
            r_res_flush     <= 1'b0;
            r_out_valid     <= 1'b0;
            r_out_hit       <= 1'b0;
            r_out_frame     <= '0;
            r_out_flush     <= 1'b0;
            r_out_faults    <= '0;
            r_out_flushes   <= '0;
            r_out_refs      <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_frames_in_use <= i_cfg.data;
            end
            r_state       <= n_state;
            r_fill        <= n_fill;
            r_fp          <= n_fp;
            r_time        <= n_time;
            r_faults      <= n_faults;
            r_flushes     <= n_flushes;
            r_refs        <= n_refs;
            r_n           <= n_n;
            r_lim         <= n_lim;
            r_rd_idx      <= n_rd_idx;
            r_pend        <= n_pend;
            r_pend_idx    <= n_pend_idx;
            r_tag         <= n_tag;
            r_wr          <= n_wr;
            r_res_hit     <= n_res_hit;
            r_res_frame   <= n_res_frame;
            r_res_flush   <= n_res_flush;
            r_out_valid   <= n_out_valid;
            r_out_hit     <= n_out_hit;
            r_out_frame   <= n_out_frame;
            r_out_flush   <= n_out_flush;
            r_out_faults  <= n_out_faults;
            r_out_flushes <= n_out_flushes;
            r_out_refs    <= n_out_refs;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.hit         = r_out_hit;
    assign o_out.frame_index = r_out_frame;
    assign o_out.flushed     = r_out_flush;
    assign o_out.fault_total = r_out_faults;
    assign o_out.flush_total = r_out_flushes;
    assign o_out.ref_total   = r_out_refs;

    lpr_frame_mem #(
        .DEPTH  (FRAMES),
        .WIDTH  (ENT_W),
        .ADDR_W (FRAME_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[FRAME_W-1:0]),
        .o_rd_data (rd_data)
    );

    lpr_scan #(
        .FRAME_W (FRAME_W),
        .TAG_W   (TAG_W),
        .STAMP_W (STAMP_WIDTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_idx       (r_pend_idx),
        .i_tag       (r_tag),
        .i_ent_tag   (rd_data[ENT_W-2 -: TAG_W]),
        .i_ent_stamp (rd_data[STAMP_WIDTH-1:0]),
        .i_ent_dirty (rd_data[ENT_W-1]),
        .o_sts       (scan_sts),
        .o_hit_idx   (hit_idx),
        .o_old_idx   (old_idx)
    );

endmodule

@@ tb/sv/lru_page_replacement_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_test
// Self-checking bench for the LRU frame table. A short table of directed
// references and frame-count writes runs first. Random phases follow, one
// for each entry of the frame-count list. Every result beat is compared with
// its typed-in result or with a behavioral LRU table kept alongside the block.
// ----------------------------------------------------------------------------
module lru_page_replacement_test;
    import lpr_pkg::*;

    localparam int ADDR_W  = ADDR_W_DEF;
    localparam int STAMP_W = STAMP_W_DEF;
    localparam int FRAME_W = FRAME_W_DEF;
    localparam int FRAMES  = FRAMES_DEF;

    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 135;
    localparam int DIRECTED_REFS   = 19;
    localparam int SETTLE_CYCLES   = 80;
    localparam int PRESSURE_AT     = DIRECTED_REFS + 6 * PHASE_ITEMS + 40;
    localparam int PRESSURE_CYCLES = 500;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_index;
        logic               flushed;
        logic [COUNT_W-1:0] fault_total;
        logic [COUNT_W-1:0] flush_total;
        logic [COUNT_W-1:0] ref_total;
    } t_page_result;

    // A fixed row carries its result typed in; a lookup row is checked
    // against the LRU table; a frames row writes the frame count.
    typedef enum logic [1:0] {ROW_LOOKUP, ROW_FIXED, ROW_FRAMES} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [ADDR_W-1:0]  value;
        t_page_result       want;
    } t_step_row;

    localparam t_step_row DIRECTED_STEPS [24] = '{
        '{ROW_FIXED,  27'h0000000, '{1'b0, 6'd0, 1'b0, 32'd1, 32'd0, 32'd1}},
        '{ROW_FIXED,  27'h0000001, '{1'b1, 6'd0, 1'b0, 32'd1, 32'd0, 32'd2}},
        '{ROW_FIXED,  27'h7FFFFFF, '{1'b0, 6'd1, 1'b0, 32'd2, 32'd0, 32'd3}},
        '{ROW_FIXED,  27'h7FFFFFE, '{1'b1, 6'd1, 1'b0, 32'd2, 32'd0, 32'd4}},
        '{ROW_LOOKUP, 27'h5555554, '0},
        '{ROW_LOOKUP, 27'h2AAAAAB, '0},
        '{ROW_FRAMES, 27'd1,       '0},
        '{ROW_FIXED,  27'h0000000, '{1'b1, 6'd0, 1'b0, 32'd4, 32'd0, 32'd7}},
        '{ROW_FIXED,  27'h0000002, '{1'b0, 6'd0, 1'b1, 32'd5, 32'd1, 32'd8}},
        '{ROW_FIXED,  27'h7FFFFFE, '{1'b0, 6'd0, 1'b0, 32'd6, 32'd1, 32'd9}},
        '{ROW_FRAMES, 27'd0,       '0},
        '{ROW_FIXED,  27'h7FFFFFF, '{1'b1, 6'd0, 1'b0, 32'd6, 32'd1, 32'd10}},
        '{ROW_FIXED,  27'h0000004, '{1'b0, 6'd0, 1'b1, 32'd7, 32'd2, 32'd11}},
        '{ROW_FRAMES, 27'd127,     '0},
        '{ROW_FIXED,  27'h7FFFFFE, '{1'b1, 6'd1, 1'b0, 32'd7, 32'd2, 32'd12}},
        '{ROW_LOOKUP, 27'h0001000, '0},
        '{ROW_LOOKUP, 27'h0001001, '0},
        '{ROW_FRAMES, 27'd2,       '0},
        '{ROW_LOOKUP, 27'h0000008, '0},
        '{ROW_LOOKUP, 27'h000000B, '0},
        '{ROW_LOOKUP, 27'h0000010, '0},
        '{ROW_LOOKUP, 27'h0000009, '0},
        '{ROW_FRAMES, 27'd64,      '0},
        '{ROW_LOOKUP, 27'h4000001, '0}
    };

    // Covers every bit of the register low and high, plus both clamps.
    localparam logic [CFG_W-1:0] PHASE_FRAMES [PHASES] = '{
        7'd64, 7'd3, 7'd1, 7'd127, 7'd0, 7'd33, 7'd64, 7'd12
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    lpr_cfg_if cfg_if ();
    lpr_in_if  ref_if ();
    lpr_out_if res_if ();

    lru_page_replacement DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (ref_if),
        .o_out   (res_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Behavioral frame table.
    bit                  slot_valid [FRAMES];
    bit                  slot_dirty [FRAMES];
    bit [ADDR_W-1:0]     slot_tag   [FRAMES];
    bit [STAMP_W-1:0]    slot_stamp [FRAMES];
    int unsigned         next_free;
    bit [STAMP_W-1:0]    now_stamp;
    bit [COUNT_W-1:0]    faults_seen;
    bit [COUNT_W-1:0]    flushes_seen;
    bit [COUNT_W-1:0]    refs_seen;
    bit [CFG_W-1:0]      frames_reg = CFG_W'(CFG_RESET);

    t_page_result        lookups_in_flight [$];
    int unsigned         mismatches;
    int unsigned         results_checked;
    int unsigned         send_idle_pct;
    int unsigned         take_idle_pct;

    function automatic int unsigned frames_active(input logic [CFG_W-1:0] count);
        frames_active = (count == 0) ? 1 : (count > FRAMES) ? FRAMES : int'(count);
    endfunction

    function automatic t_page_result lru_lookup(input logic [ADDR_W-1:0] word);
        t_page_result        r;
        int unsigned         n;
        int unsigned         i;
        int unsigned         victim;
        logic [ADDR_W-1:0]   tag;
        logic                is_write;
        logic                found;
        logic [STAMP_W-1:0]  oldest;
        n        = frames_active(frames_reg);
        is_write = word[0];
        tag      = {word[ADDR_W-1:1], 1'b0};
        r        = '0;
        victim   = 0;
        if (now_stamp != '1) now_stamp++;
        if (refs_seen != '1) refs_seen++;
        if (next_free >= n) next_free = 0;

        for (i = 0; i < n; i++) begin
            if (!r.hit && slot_valid[i] && slot_tag[i] == tag) begin
                r.hit  = 1'b1;
                victim = i;
            end
        end

        if (r.hit) begin
            slot_stamp[victim] = now_stamp;
            if (is_write) slot_dirty[victim] = 1'b1;
        end else begin
            if (faults_seen != '1) faults_seen++;
            if (!slot_valid[next_free]) begin
                victim    = next_free;
                next_free = (next_free + 1 >= n) ? 0 : next_free + 1;
            end else begin
                // Strict compare keeps the lowest index among equal stamps.
                found  = 1'b0;
                oldest = '0;
                for (i = 0; i < n; i++) begin
                    if (slot_valid[i] && (!found || slot_stamp[i] < oldest)) begin
                        found  = 1'b1;
                        oldest = slot_stamp[i];
                        victim = i;
                    end
                end
                r.flushed = slot_dirty[victim];
            end
            if (r.flushed && flushes_seen != '1) flushes_seen++;
            slot_valid[victim] = 1'b1;
            slot_dirty[victim] = is_write;
            slot_tag[victim]   = tag;
            slot_stamp[victim] = now_stamp;
        end

        r.frame_index = FRAME_W'(victim);
        r.fault_total = faults_seen;
        r.flush_total = flushes_seen;
        r.ref_total   = refs_seen;
        return r;
    endfunction

    task automatic offer_ref(input logic [ADDR_W-1:0] word, input logic fixed,
                             input t_page_result want);
        t_page_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            ref_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        ref_if.valid     <= 1'b1;
        ref_if.ref_value <= word;
        do @(posedge i_clk); while (!ref_if.ready);
        r = lru_lookup(word);
        lookups_in_flight.push_back(fixed ? want : r);
    endtask

    // The frame count may only change while no reference is in flight.
    task automatic set_frames(input logic [CFG_W-1:0] count);
        ref_if.valid <= 1'b0;
        while (lookups_in_flight.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= count;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        frames_reg = count;
    endtask

    always @(posedge i_clk) begin : result_check
        t_page_result got;
        t_page_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.hit, res_if.frame_index, res_if.flushed,
                    res_if.fault_total, res_if.flush_total, res_if.ref_total};
            if (lookups_in_flight.size() == 0) begin
                if (mismatches < 10)
                    $display("result beat %0d arrived with no reference outstanding",
                             results_checked);
                mismatches++;
            end else begin
                want = lookups_in_flight.pop_front();
                if (got !== want) begin
                    if (mismatches < 10) begin
                        $write("mismatch at beat %0d: expected hit=%0d frame=%0d ",
                               results_checked, want.hit, want.frame_index);
                        $write("flushed=%0d faults=%0d flushes=%0d refs=%0d, ",
                               want.flushed, want.fault_total, want.flush_total,
                               want.ref_total);
                        $write("got hit=%0d frame=%0d flushed=%0d ",
                               got.hit, got.frame_index, got.flushed);
                        $display("faults=%0d flushes=%0d refs=%0d",
                                 got.fault_total, got.flush_total, got.ref_total);
                    end
                    mismatches++;
                end
            end
            results_checked++;
        end
    end

    // Result side pacing, including one long hold-off that backs the block up.
    initial begin : sink_pacing
        int unsigned hold_left;
        int unsigned taken;
        bit          pressure_done;
        hold_left     = 0;
        taken         = 0;
        pressure_done = 1'b0;
        res_if.ready  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) taken++;
            if (hold_left != 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (!pressure_done && taken >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= i_rst_n && ($urandom_range(99) >= take_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned       p;
        int unsigned       k;
        int unsigned       pool_size;
        logic [ADDR_W-1:0] word;
        logic [ADDR_W-1:0] tag_pool [$];
        ref_if.valid     = 1'b0;
        ref_if.ref_value = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = '0;
        i_rst_n          = 1'b0;
        send_idle_pct    = 15;
        take_idle_pct    = 74;
        mismatches       = 0;
        results_checked  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_STEPS[d]) begin
            if (DIRECTED_STEPS[d].kind == ROW_FRAMES)
                set_frames(DIRECTED_STEPS[d].value[CFG_W-1:0]);
            else
                offer_ref(DIRECTED_STEPS[d].value, DIRECTED_STEPS[d].kind == ROW_FIXED,
                          DIRECTED_STEPS[d].want);
        end

        for (p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 15;
                take_idle_pct = 74;
            end else if (p < 6) begin
                send_idle_pct = 74;
                take_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            set_frames(PHASE_FRAMES[p]);

            // A pool as large as the table or a little larger gives a mix of hits,
            // fills and evictions; a share of fully random beats adds noise.
            tag_pool.delete();
            pool_size = frames_active(frames_reg);
            pool_size = pool_size + $urandom_range(pool_size / 2 + 2);
            for (k = 0; k < pool_size; k++) begin
                word    = ADDR_W'($urandom);
                word[0] = 1'b0;
                tag_pool.push_back(word);
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 15) begin
                    word = ADDR_W'($urandom);
                end else begin
                    word    = tag_pool[$urandom_range(tag_pool.size() - 1)];
                    word[0] = 1'($urandom_range(1));
                end
                offer_ref(word, 1'b0, '0);
            end
        end

        ref_if.valid <= 1'b0;
        while (lookups_in_flight.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && lookups_in_flight.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/lpr_pkg.sv
sv/lpr_cfg_if.sv
sv/lpr_in_if.sv
sv/lpr_out_if.sv
sv/lpr_frame_mem.sv
sv/lpr_scan.sv
sv/lru_page_replacement.sv
tb/sv/lru_page_replacement_test.sv
